// File: hdl/assert_macros.svh
// assertion macros shared by the delimited field extractor
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check that is switched off while reset is held
`define DFEC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// check that holds in every cycle, reset included
`define DFEC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define DFEC_ASSERT(label, prop)
`define DFEC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// File: hdl/dfec_pkg.sv
// types, constants and register codes of the delimited field extractor
// no dependencies; used by the configuration, parser, output buffer and top files and the bench
package dfec_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SEPARATOR  = 3'd0,
        REG_TERMINATOR = 3'd1,
        REG_FIELD_SEL  = 3'd2,
        REG_MAX_LEN    = 3'd3,
        REG_DECIMAL    = 3'd4,
        REG_RANGE_MIN  = 3'd5,
        REG_RANGE_MAX  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PHASE_OPEN = 2'd0,
        PHASE_DONE = 2'd2
    } phase_t;

    localparam logic [7:0]  SEPARATOR_RESET  = 8'd44;
    localparam logic [7:0]  TERMINATOR_RESET = 8'd10;
    localparam logic [15:0] FIELD_SEL_RESET  = 16'd0;
    localparam logic [7:0]  MAX_LEN_RESET    = 8'd32;

    localparam logic [7:0]  CHAR_0     = 8'h30;
    localparam logic [7:0]  CHAR_9     = 8'h39;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  CHAR_POINT = 8'h2E;
    localparam logic [7:0]  CHAR_NUL   = 8'h00;

    localparam int MAG_W = 33;
    localparam int ACC_W = MAG_W + 4;
    localparam logic [MAG_W-1:0] MAG_SAT   = {1'b1, 32'h0000_0000};
    localparam logic [ACC_W-1:0] MAG_LIMIT = {5'd0, 32'hFFFF_FFFF};
    localparam logic [15:0]      SEP_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [7:0]         separator_char;
        logic [7:0]         terminator_char;
        logic [15:0]        field_select;
        logic [7:0]         max_field_len;
        logic               decimal_mode;
        logic signed [33:0] range_min;
        logic signed [33:0] range_max;
        // negated bounds, used for negative values
        logic signed [33:0] range_min_neg;
        logic signed [33:0] range_max_neg;
    } cfg_t;

    typedef struct packed {
        logic             number_ok;
        logic             point_seen;
        logic             value_negative;
        logic             nul_seen;
        logic [MAG_W-1:0] value_magnitude;
    } numstate_t;

    typedef struct packed {
        logic       is_summary;
        logic [7:0] field_char;
        logic [7:0] field_length;
        logic       overflow;
        logic       number_valid;
        logic       in_range;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: hdl/dfec_if.sv
// valid/ready channels of the delimited field extractor
// no dependencies
interface dfec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface dfec_out_if;
    logic       valid;
    logic       ready;
    logic       is_summary;
    logic [7:0] field_char;
    logic [7:0] field_length;
    logic       overflow;
    logic       number_valid;
    logic       in_range;

    modport source (
        output valid, output is_summary, output field_char, output field_length,
        output overflow, output number_valid, output in_range, input ready
    );
    modport sink (
        input valid, input is_summary, input field_char, input field_length,
        input overflow, input number_valid, input in_range, output ready
    );
endinterface

// File: hdl/dfec_cfg.sv
// configuration registers of the delimited field extractor
// depends on dfec_pkg
module dfec_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dfec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dfec_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output dfec_pkg::cfg_t                     cfg
);

    dfec_pkg::cfg_t     cfg_reg;
    dfec_pkg::cfg_t     cfg_next;
    logic signed [33:0] wdata_sext;

    always_comb
    begin
        wdata_sext = $signed({{2{cfg_wdata[31]}}, cfg_wdata});
        cfg_next   = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dfec_pkg::REG_SEPARATOR:  cfg_next.separator_char  = cfg_wdata[7:0];
                dfec_pkg::REG_TERMINATOR: cfg_next.terminator_char = cfg_wdata[7:0];
                dfec_pkg::REG_FIELD_SEL:  cfg_next.field_select    = cfg_wdata[15:0];
                dfec_pkg::REG_MAX_LEN:    cfg_next.max_field_len   = cfg_wdata[7:0];
                dfec_pkg::REG_DECIMAL:    cfg_next.decimal_mode    = cfg_wdata[0];
                dfec_pkg::REG_RANGE_MIN:
                begin
                    cfg_next.range_min     = wdata_sext;
                    cfg_next.range_min_neg = 34'sd0 - wdata_sext;
                end
                dfec_pkg::REG_RANGE_MAX:
                begin
                    cfg_next.range_max     = wdata_sext;
                    cfg_next.range_max_neg = 34'sd0 - wdata_sext;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator_char  <= dfec_pkg::SEPARATOR_RESET;
            cfg_reg.terminator_char <= dfec_pkg::TERMINATOR_RESET;
            cfg_reg.field_select    <= dfec_pkg::FIELD_SEL_RESET;
            cfg_reg.max_field_len   <= dfec_pkg::MAX_LEN_RESET;
            cfg_reg.decimal_mode    <= 1'b0;
            cfg_reg.range_min       <= 34'sd0;
            cfg_reg.range_max       <= 34'sd0;
            cfg_reg.range_min_neg   <= 34'sd0;
            cfg_reg.range_max_neg   <= 34'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/dfec_parse.sv
// input register, record state and result generation for one byte per cycle while the output buffer has room
// depends on dfec_pkg, dfec_if and assert_macros.svh
`include "assert_macros.svh"

module dfec_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  dfec_pkg::cfg_t    cfg,
    dfec_in_if.sink           data,
    input  logic [1:0]        room,
    output dfec_pkg::push_t   push
);

    logic                  vld_reg;
    logic [7:0]            byte_reg;
    logic                  eob_reg;

    logic [15:0]           seps_reg, seps_next;
    logic [7:0]            chars_reg, chars_next;
    dfec_pkg::phase_t      phase_reg, phase_next;
    dfec_pkg::numstate_t   num_reg, num_next;

    dfec_pkg::numstate_t   num_chk;
    dfec_pkg::result_t     sum_cur, sum_new, char_res;
    logic [7:0]            chars_inc;
    logic [7:0]            lim;
    logic                  active, is_sep, is_term;
    logic                  restart;
    logic [1:0]            n_res;
    logic                  proc;
    logic                  load;

    function automatic dfec_pkg::numstate_t check_char(
        input logic [7:0]          c,
        input logic [7:0]          pos,
        input dfec_pkg::numstate_t s,
        input logic                dec
    );
        dfec_pkg::numstate_t          r;
        logic [dfec_pkg::ACC_W-1:0]   acc;
        r   = s;
        acc = ({4'd0, s.value_magnitude} << 3) + ({4'd0, s.value_magnitude} << 1)
              + {{(dfec_pkg::ACC_W-4){1'b0}}, c[3:0]};
        if (s.number_ok && !s.nul_seen)
        begin
            if (c >= dfec_pkg::CHAR_0 && c <= dfec_pkg::CHAR_9)
            begin
                if (!s.point_seen)
                begin
                    // saturate just above 32 bits
                    if (acc > dfec_pkg::MAG_LIMIT)
                        r.value_magnitude = dfec_pkg::MAG_SAT;
                    else
                        r.value_magnitude = acc[dfec_pkg::MAG_W-1:0];
                end
            end
            else if (c == dfec_pkg::CHAR_PLUS || c == dfec_pkg::CHAR_MINUS)
            begin
                if (pos != 8'd0)
                    r.number_ok = 1'b0;
                else
                    r.value_negative = (c == dfec_pkg::CHAR_MINUS);
            end
            else if (c == dfec_pkg::CHAR_POINT)
            begin
                if (!dec || pos == 8'd0 || s.point_seen)
                    r.number_ok = 1'b0;
                else
                    r.point_seen = 1'b1;
            end
            else if (c == dfec_pkg::CHAR_NUL)
            begin
                r.nul_seen = 1'b1;
            end
            else
            begin
                r.number_ok = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic dfec_pkg::result_t summary(
        input logic [7:0]          chars,
        input logic [7:0]          limit,
        input dfec_pkg::numstate_t s,
        input dfec_pkg::cfg_t      c
    );
        dfec_pkg::result_t   r;
        logic                ovf;
        logic                valid;
        logic                in_bounds;
        logic signed [33:0]  mag;
        ovf   = chars >= limit;
        valid = ovf || s.number_ok;
        // overflowed field counts as value zero
        mag   = ovf ? 34'sd0 : $signed({1'b0, s.value_magnitude});
        if (!ovf && s.value_negative)
            in_bounds = (mag <= c.range_min_neg) && (mag >= c.range_max_neg);
        else
            in_bounds = (mag >= c.range_min) && (mag <= c.range_max);
        r.is_summary   = 1'b1;
        r.field_char   = 8'd0;
        r.field_length = ovf ? 8'd0 : chars;
        r.overflow     = ovf;
        r.number_valid = valid;
        r.in_range     = valid && !c.decimal_mode && (c.range_min <= c.range_max)
                         && in_bounds;
        return r;
    endfunction

    always_comb
    begin
        lim       = (cfg.max_field_len == 8'd0) ? 8'd1 : cfg.max_field_len;
        active    = (phase_reg != dfec_pkg::PHASE_DONE) && (seps_reg == cfg.field_select);
        is_sep    = byte_reg == cfg.separator_char;
        is_term   = byte_reg == cfg.terminator_char;
        chars_inc = chars_reg + 8'd1;
        num_chk   = check_char(byte_reg, chars_reg, num_reg, cfg.decimal_mode);
        sum_cur   = summary(chars_reg, lim, num_reg, cfg);
        sum_new   = summary(chars_inc, lim, num_chk, cfg);

        char_res.is_summary   = 1'b0;
        char_res.field_char   = byte_reg;
        char_res.field_length = 8'd0;
        char_res.overflow     = 1'b0;
        char_res.number_valid = 1'b0;
        char_res.in_range     = 1'b0;

        n_res       = 2'd0;
        restart     = 1'b0;
        push.first  = sum_cur;
        push.second = sum_new;
        seps_next   = seps_reg;
        chars_next  = chars_reg;
        num_next    = num_reg;
        phase_next  = phase_reg;

        if (phase_reg == dfec_pkg::PHASE_DONE)
        begin
            // closed field: skip bytes until the record ends
            restart = is_term || eob_reg;
        end
        else if (is_sep)
        begin
            if (seps_reg != dfec_pkg::SEP_MAX)
                seps_next = seps_reg + 16'd1;
            if (active)
            begin
                n_res      = 2'd1;
                phase_next = dfec_pkg::PHASE_DONE;
            end
            if (eob_reg)
            begin
                n_res   = 2'd1;
                restart = 1'b1;
            end
        end
        else if (is_term)
        begin
            n_res   = 2'd1;
            restart = 1'b1;
        end
        else if (active)
        begin
            push.first = char_res;
            num_next   = num_chk;
            chars_next = chars_inc;
            n_res      = (chars_inc >= lim || eob_reg) ? 2'd2 : 2'd1;
            if (chars_inc >= lim)
                phase_next = dfec_pkg::PHASE_DONE;
            restart = eob_reg;
        end
        else if (eob_reg)
        begin
            // selected field never appeared
            n_res   = 2'd1;
            restart = 1'b1;
        end

        proc       = vld_reg && (n_res <= room);
        push.count = proc ? n_res : 2'd0;
    end

    assign data.ready = !vld_reg || proc;
    assign load       = data.valid && data.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= 1'b1;
        end
        else if (proc)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= data.data_byte;
            eob_reg  <= data.end_of_buffer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seps_reg                <= 16'd0;
            chars_reg               <= 8'd0;
            phase_reg               <= dfec_pkg::PHASE_OPEN;
            num_reg.number_ok       <= 1'b1;
            num_reg.point_seen      <= 1'b0;
            num_reg.value_negative  <= 1'b0;
            num_reg.nul_seen        <= 1'b0;
            num_reg.value_magnitude <= '0;
        end
        else if (proc)
        begin
            if (restart)
            begin
                seps_reg                <= 16'd0;
                chars_reg               <= 8'd0;
                phase_reg               <= dfec_pkg::PHASE_OPEN;
                num_reg.number_ok       <= 1'b1;
                num_reg.point_seen      <= 1'b0;
                num_reg.value_negative  <= 1'b0;
                num_reg.nul_seen        <= 1'b0;
                num_reg.value_magnitude <= '0;
            end
            else
            begin
                seps_reg  <= seps_next;
                chars_reg <= chars_next;
                phase_reg <= phase_next;
                num_reg   <= num_next;
            end
        end
    end

    `DFEC_ASSERT(a_pair_ends_in_summary, (push.count == 2'd2) |-> (push.second.is_summary && !push.first.is_summary))
    `DFEC_ASSERT(a_closed_field_silent, (phase_reg == dfec_pkg::PHASE_DONE) |-> (push.count == 2'd0))
    `DFEC_ASSERT(a_restart_clears, (proc && restart) |=> (seps_reg == 16'd0 && chars_reg == 8'd0))

endmodule

// File: hdl/dfec_out_buf.sv
// two-entry result buffer that feeds the output channel one item per cycle while the receiver is ready
// depends on dfec_pkg, dfec_if and assert_macros.svh
`include "assert_macros.svh"

module dfec_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  dfec_pkg::push_t   push,
    output logic [1:0]        room,
    dfec_out_if.source        result
);

    logic [1:0]         cnt_reg, cnt_next;
    logic [1:0]         cnt_after;
    logic               pop;
    dfec_pkg::result_t  slot0_reg, slot0_next;
    dfec_pkg::result_t  slot1_reg, slot1_next;

    always_comb
    begin
        pop        = (cnt_reg != 2'd0) && result.ready;
        cnt_after  = cnt_reg - {1'b0, pop};
        room       = 2'd2 - cnt_after;
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        if (cnt_after == 2'd0)
        begin
            if (push.count != 2'd0)
                slot0_next = push.first;
            if (push.count == 2'd2)
                slot1_next = push.second;
        end
        else if (cnt_after == 2'd1 && push.count != 2'd0)
        begin
            slot1_next = push.first;
        end
        cnt_next = cnt_after + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign result.valid        = cnt_reg != 2'd0;
    assign result.is_summary   = slot0_reg.is_summary;
    assign result.field_char   = slot0_reg.field_char;
    assign result.field_length = slot0_reg.field_length;
    assign result.overflow     = slot0_reg.overflow;
    assign result.number_valid = slot0_reg.number_valid;
    assign result.in_range     = slot0_reg.in_range;

    `DFEC_ASSERT_ALWAYS(a_count_bounded, cnt_reg != 2'd3)
    `DFEC_ASSERT_ALWAYS(a_no_overrun, push.count <= room)
    `DFEC_ASSERT(a_empty_push_shows, (cnt_reg == 2'd0 && push.count != 2'd0) |=> result.valid)

endmodule

// File: hdl/delimited_field_extract_check.sv
// Delimited field extractor: takes record bytes one per item, passes on the bytes of the
// selected field as character results and closes the field with a summary carrying length,
// overflow, number validity and an integer range check. A byte is held in the input register
// until it is processed, and its results are then registered in the output buffer. One item
// is taken every cycle while the output side keeps up; results leave at one per cycle while
// the receiver is ready, so a byte that gives a character and a summary (field reaching
// max_field_len, or last byte of the buffer) leaves one result queued, and a later byte that
// also gives two results waits until the two-entry output buffer has drained. Configuration
// writes take effect on the next cycle. No clearing pass after reset.
// depends on dfec_pkg, dfec_if, dfec_cfg, dfec_parse and dfec_out_buf
module delimited_field_extract_check (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dfec_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dfec_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    dfec_in_if.sink                            data,
    dfec_out_if.source                         result
);

    dfec_pkg::cfg_t   cfg;
    dfec_pkg::push_t  push;
    logic [1:0]       room;

    dfec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dfec_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .data  (data),
        .room  (room),
        .push  (push)
    );

    dfec_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

// File: verif/delimited_field_extract_check_test.sv
// self-checking bench for the delimited field extractor: directed records, then random records
// under changing register settings, with a scoreboard that predicts every character and summary
// depends on dfec_pkg, dfec_if and delimited_field_extract_check
module delimited_field_extract_check_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dfec_pkg::*;

    localparam int RANGE_LOW  = 32'sh8000_0000;
    localparam int RANGE_HIGH = 32'sh7FFF_FFFF;
    localparam int PHASE_ITEMS = 138;

    typedef struct {
        logic [7:0]  sep;
        logic [7:0]  term;
        logic [15:0] fsel;
        logic [7:0]  max_len;
        logic        dec;
        int          rmin;
        int          rmax;
    } settings_t;

    class extract_scoreboard;
        logic [7:0]  sep_char;
        logic [7:0]  term_char;
        logic [15:0] wanted_field;
        logic [7:0]  max_len;
        logic        decimal_on;
        int          lo_bound;
        int          hi_bound;

        logic [15:0] seps_seen;
        int unsigned field_chars;
        phase_t      rec_phase;
        bit          digits_ok;
        bit          point_found;
        bit          minus_sign;
        bit          nul_found;
        longint      magnitude;

        result_t     due_results[$];
        int          fail_count;

        function new();
            sep_char     = SEPARATOR_RESET;
            term_char    = TERMINATOR_RESET;
            wanted_field = FIELD_SEL_RESET;
            max_len      = MAX_LEN_RESET;
            decimal_on   = 1'b0;
            lo_bound     = 0;
            hi_bound     = 0;
            fail_count   = 0;
            restart_record();
        endfunction

        function void restart_record();
            seps_seen   = '0;
            field_chars = 0;
            rec_phase   = PHASE_OPEN;
            digits_ok   = 1'b1;
            point_found = 1'b0;
            minus_sign  = 1'b0;
            nul_found   = 1'b0;
            magnitude   = 0;
        endfunction

        function void apply_reg(cfg_reg_t idx, logic [31:0] value);
            case (idx)
                REG_SEPARATOR:  sep_char     = value[7:0];
                REG_TERMINATOR: term_char    = value[7:0];
                REG_FIELD_SEL:  wanted_field = value[15:0];
                REG_MAX_LEN:    max_len      = value[7:0];
                REG_DECIMAL:    decimal_on   = value[0];
                REG_RANGE_MIN:  lo_bound     = value;
                REG_RANGE_MAX:  hi_bound     = value;
                default: ;
            endcase
        endfunction

        function int unsigned length_limit();
            return (max_len == 0) ? 1 : max_len;
        endfunction

        function void close_field();
            bit      ovf;
            bit      valid;
            longint  v;
            result_t r;
            ovf   = field_chars >= length_limit();
            valid = ovf || digits_ok;
            // an overflowed field is judged as an empty one
            v = 0;
            if (!ovf)
                v = minus_sign ? -magnitude : magnitude;
            r = '0;
            r.is_summary   = 1'b1;
            r.field_length = ovf ? 8'd0 : field_chars[7:0];
            r.overflow     = ovf;
            r.number_valid = valid;
            r.in_range     = valid && !decimal_on && lo_bound <= hi_bound
                             && v >= lo_bound && v <= hi_bound;
            due_results.push_back(r);
            rec_phase = PHASE_DONE;
        endfunction

        function void scan_number(logic [7:0] b, int unsigned pos);
            if (!digits_ok || nul_found)
                return;
            if (b >= CHAR_0 && b <= CHAR_9)
            begin
                if (!point_found)
                begin
                    magnitude = magnitude * 10 + longint'(b - CHAR_0);
                    // saturate just above 32 bits
                    if (magnitude > 64'hFFFF_FFFF)
                        magnitude = 64'h1_0000_0000;
                end
            end
            else if (b == CHAR_PLUS || b == CHAR_MINUS)
            begin
                if (pos != 0)
                    digits_ok = 1'b0;
                else
                    minus_sign = (b == CHAR_MINUS);
            end
            else if (b == CHAR_POINT)
            begin
                if (!decimal_on || pos == 0 || point_found)
                    digits_ok = 1'b0;
                else
                    point_found = 1'b1;
            end
            else if (b == CHAR_NUL)
            begin
                nul_found = 1'b1;
            end
            else
            begin
                digits_ok = 1'b0;
            end
        endfunction

        function void take_byte(logic [7:0] b, logic eob);
            bit      active;
            result_t r;
            active = rec_phase != PHASE_DONE && seps_seen == wanted_field;
            if (rec_phase == PHASE_DONE)
            begin
                if (b == term_char || eob)
                    restart_record();
                return;
            end
            if (b == sep_char)
            begin
                if (active)
                    close_field();
                if (seps_seen != SEP_MAX)
                    seps_seen++;
            end
            else if (b == term_char)
            begin
                close_field();
                restart_record();
                return;
            end
            else if (active)
            begin
                r = '0;
                r.field_char = b;
                due_results.push_back(r);
                scan_number(b, field_chars);
                field_chars++;
                if (field_chars >= length_limit())
                    close_field();
            end
            if (eob)
            begin
                if (rec_phase != PHASE_DONE)
                    close_field();
                restart_record();
            end
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $error("result with nothing expected: is_summary %0d, field_char %0d",
                       got.is_summary, got.field_char);
                fail_count++;
                return;
            end
            want = due_results.pop_front();
            check_field("is_summary", want.is_summary, got.is_summary);
            check_field("field_char", want.field_char, got.field_char);
            check_field("field_length", want.field_length, got.field_length);
            check_field("overflow", want.overflow, got.overflow);
            check_field("number_valid", want.number_valid, got.number_valid);
            check_field("in_range", want.in_range, got.in_range);
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    dfec_in_if  in_ch ();
    dfec_out_if result_ch ();

    delimited_field_extract_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .data      (in_ch),
        .result    (result_ch)
    );

    extract_scoreboard board = new();

    int          gap_odds = 0;
    int          stall_odds = 0;
    int          sent_count = 0;
    settings_t   cur;
    logic [7:0]  record_bytes[$];
    logic        last_eob;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin : watch_results
        result_t got;
        if (rst_n === 1'b1 && result_ch.valid && result_ch.ready)
        begin
            got.is_summary   = result_ch.is_summary;
            got.field_char   = result_ch.field_char;
            got.field_length = result_ch.field_length;
            got.overflow     = result_ch.overflow;
            got.number_valid = result_ch.number_valid;
            got.in_range     = result_ch.in_range;
            board.match_result(got);
        end
    end

    // receiver back-pressure in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                stall_left = $urandom_range(0, 9);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // valid stays high between back-to-back items; within this task only a gap lowers it
    task automatic send_byte(input logic [7:0] b, input logic eob);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_buffer <= eob;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.take_byte(b, eob);
        sent_count++;
    endtask

    task automatic send_text(input string s, input logic eob_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eob_last && i == s.len() - 1);
    endtask

    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        // a byte that gives no result may still sit in the pipeline
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] reg_value(settings_t s, cfg_reg_t r);
        case (r)
            REG_SEPARATOR:  return {24'd0, s.sep};
            REG_TERMINATOR: return {24'd0, s.term};
            REG_FIELD_SEL:  return {16'd0, s.fsel};
            REG_MAX_LEN:    return {24'd0, s.max_len};
            REG_DECIMAL:    return {31'd0, s.dec};
            REG_RANGE_MIN:  return s.rmin;
            REG_RANGE_MAX:  return s.rmax;
            default:        return '0;
        endcase
    endfunction

    task automatic program_regs(input settings_t s);
        cfg_reg_t r;
        r = r.first();
        do
        begin
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_wdata <= reg_value(s, r);
            @(posedge clk);
            board.apply_reg(r, reg_value(s, r));
            r = r.next();
        end
        while (r != r.first());
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic settings_t choose_settings(int p);
        settings_t s;
        s.sep     = SEPARATOR_RESET;
        s.term    = TERMINATOR_RESET;
        s.fsel    = 16'd0;
        s.max_len = MAX_LEN_RESET;
        s.dec     = 1'b0;
        s.rmin    = RANGE_LOW;
        s.rmax    = RANGE_HIGH;
        case (p)
            // zero length limit acts as one
            3: s.max_len = 8'd0;
            // field never reached
            4:
            begin
                s.fsel    = 16'hFFFF;
                s.max_len = 8'd255;
            end
            5:
            begin
                s.fsel    = 16'd2;
                s.max_len = 8'd12;
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    s.sep = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 7))
                    0:       s.term = s.sep;
                    1, 2, 3: s.term = 8'($urandom_range(0, 255));
                    default: ;
                endcase
                s.fsel = 16'($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0:       s.max_len = 8'($urandom_range(1, 8));
                    1:       s.max_len = 8'($urandom_range(9, 40));
                    2:       s.max_len = 8'd255;
                    default: s.max_len = 8'($urandom_range(0, 1));
                endcase
                s.dec = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0:
                    begin
                        s.rmin = -int'($urandom_range(0, 500));
                        s.rmax = int'($urandom_range(0, 500));
                    end
                    1:
                    begin
                        s.rmin = int'($urandom_range(0, 99));
                        s.rmax = s.rmin + int'($urandom_range(0, 99));
                    end
                    // crossed bounds
                    2:
                    begin
                        s.rmin = int'($urandom_range(1, 100));
                        s.rmax = -int'($urandom_range(0, 100));
                    end
                    default: ;
                endcase
            end
        endcase
        return s;
    endfunction

    // field content never holds the separator or terminator
    function automatic void push_content(logic [7:0] b);
        while (b == cur.sep || b == cur.term)
            b = 8'($urandom_range(0, 255));
        record_bytes.push_back(b);
    endfunction

    function automatic void add_digits(int n);
        repeat (n) push_content(8'(CHAR_0 + $urandom_range(0, 9)));
    endfunction

    function automatic void add_selected_field();
        logic [7:0] stray;
        case ($urandom_range(0, 9))
            0: ;
            1, 2, 3, 4:
            begin
                case ($urandom_range(0, 5))
                    0: push_content(CHAR_MINUS);
                    1: push_content(CHAR_PLUS);
                    default: ;
                endcase
                add_digits($urandom_range(0, 3) == 0 ? $urandom_range(4, 12)
                                                     : $urandom_range(1, 3));
                if (cur.dec && $urandom_range(0, 1))
                begin
                    push_content(CHAR_POINT);
                    add_digits($urandom_range(0, 3));
                end
            end
            5: push_content($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
            6:
            begin
                add_digits($urandom_range(0, 3));
                case ($urandom_range(0, 4))
                    0:       stray = CHAR_PLUS;
                    1:       stray = CHAR_MINUS;
                    2:       stray = CHAR_POINT;
                    3:       stray = CHAR_NUL;
                    default: stray = 8'($urandom_range(0, 255));
                endcase
                push_content(stray);
                add_digits($urandom_range(0, 3));
                if ($urandom_range(0, 1))
                    push_content(CHAR_POINT);
            end
            7:
            begin
                push_content(CHAR_POINT);
                add_digits($urandom_range(0, 3));
            end
            8: repeat ($urandom_range(1, 6)) push_content(8'($urandom_range(0, 255)));
            default: add_digits($urandom_range(10, 40));
        endcase
    endfunction

    function automatic void build_record();
        int nf;
        record_bytes.delete();
        if (cur.fsel > 3)
            nf = $urandom_range(1, 4);
        else if ($urandom_range(0, 7) == 0)
            nf = $urandom_range(0, cur.fsel);
        else
            nf = cur.fsel + 1 + $urandom_range(0, 2);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
                record_bytes.push_back(cur.sep);
            if (f == cur.fsel)
                add_selected_field();
            else
                repeat ($urandom_range(0, 4)) push_content(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 9))
            7:
            begin
                record_bytes.push_back(cur.term);
                last_eob = 1'b1;
            end
            8, 9:
            begin
                if (record_bytes.size() == 0)
                    push_content(8'($urandom_range(0, 255)));
                last_eob = 1'b1;
            end
            default:
            begin
                record_bytes.push_back(cur.term);
                last_eob = 1'b0;
            end
        endcase
    endfunction

    initial
    begin
        int start;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_SEPARATOR;
        cfg_wdata           <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.end_of_buffer <= 1'b0;
        cur = choose_settings(3);
        cur.max_len = MAX_LEN_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: plain number, empty field, lone sign, zero byte, last-byte close
        gap_odds   = 3;
        stall_odds = 3;
        send_text("0\n", 1'b0);
        send_text(",5\n", 1'b0);
        send_text("-\n", 1'b0);
        send_byte(CHAR_NUL, 1'b0);
        send_text("x\n", 1'b0);
        send_byte(8'hFF, 1'b1);

        // separator equal to terminator, back-to-back separators, limit of one
        wait_quiet();
        cur.sep     = 8'hFF;
        cur.term    = 8'hFF;
        cur.fsel    = 16'd1;
        cur.max_len = 8'd1;
        cur.dec     = 1'b1;
        cur.rmin    = RANGE_LOW;
        cur.rmax    = RANGE_HIGH;
        program_regs(cur);
        send_text("7", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("3", 1'b1);
        send_text("1", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("2", 1'b0);
        send_byte(8'hFF, 1'b1);

        // decimal number against crossed bounds, zero byte as separator
        wait_quiet();
        cur.sep     = CHAR_NUL;
        cur.term    = 8'h3B;
        cur.fsel    = 16'd0;
        cur.max_len = 8'd255;
        cur.rmin    = 5;
        cur.rmax    = -5;
        program_regs(cur);
        send_text("+1.5;", 1'b0);

        for (int p = 3; p < 15; p++)
        begin
            wait_quiet();
            cur = choose_settings(p);
            program_regs(cur);
            // no idling in the closing phases; a receiver stall always ends
            gap_odds   = (p >= 13) ? 0 : (1 << $urandom_range(0, 3)) - 1;
            stall_odds = (p >= 13) ? 0 : (4 << $urandom_range(0, 2)) - 1;
            start = sent_count;
            while (sent_count - start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 24) == 0)
                    wait_quiet();
                if ($urandom_range(0, 9) == 0)
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                build_record();
                for (int i = 0; i < record_bytes.size(); i++)
                    send_byte(record_bytes[i], last_eob && i == record_bytes.size() - 1);
            end
        end

        wait_quiet();
        repeat (12) @(posedge clk);
        if (board.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
